### rtl/lcg_enc_pkg.sv
// ----------------------------------------------------------------------------
// LCG character obfuscation encoder package
// Shared payload types, controller/datapath interface and constants.
// ----------------------------------------------------------------------------
package lcg_enc_pkg;

    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_INC = 32'd12345;
    localparam logic [31:0] LCG_SEED = 32'd1;
    localparam logic [3:0]  LAST_IDX = 4'd15;

    typedef struct packed {
        logic [7:0] in_char;
        logic       last_group;
    } in_item_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_of_run;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SITE,
        ST_RUN
    } ctrl_state_t;

    typedef struct packed {
        logic       load;
        logic       draw_site;
        logic       draw_out;
        logic [3:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic char_nonzero;
        logic out_free;
    } dp_status_t;

    function automatic logic [6:0] alphabet(input logic [5:0] v);
        logic [6:0] c;
        c = {1'b0, v};
        if (v < 6'd26) begin
            return 7'(c + 7'd65);
        end
        else if (v < 6'd52) begin
            return 7'(c + 7'd71);
        end
        else if (v < 6'd62) begin
            return 7'(c - 7'd4);
        end
        else if (v == 6'd62) begin
            return 7'd43;
        end
        else begin
            return 7'd47;
        end
    endfunction

endpackage

### rtl/lcg_enc_ctrl.sv
// ----------------------------------------------------------------------------
// LCG encoder controller
// Sequences the optional position draw and the sixteen output draws.
// ----------------------------------------------------------------------------
module lcg_enc_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  lcg_enc_pkg::dp_status_t status,
    output lcg_enc_pkg::dp_cmd_t   cmd
);

    lcg_enc_pkg::ctrl_state_t state_reg, state_next;
    logic [3:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcg_enc_pkg::ST_IDLE;
            idx_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd.load      = 1'b0;
        cmd.draw_site = 1'b0;
        cmd.draw_out  = 1'b0;
        cmd.idx       = idx_reg;
        in_stall      = 1'b1;
        unique case (state_reg)
            lcg_enc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                idx_next = 4'd0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.char_nonzero ? lcg_enc_pkg::ST_SITE
                                                     : lcg_enc_pkg::ST_RUN;
                end
            end
            lcg_enc_pkg::ST_SITE:
            begin
                cmd.draw_site = 1'b1;
                state_next    = lcg_enc_pkg::ST_RUN;
            end
            lcg_enc_pkg::ST_RUN:
            begin
                if (status.out_free)
                begin
                    cmd.draw_out = 1'b1;
                    idx_next     = 4'(idx_reg + 4'd1);
                    if (idx_reg == lcg_enc_pkg::LAST_IDX)
                    begin
                        state_next = lcg_enc_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lcg_enc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/lcg_enc_dp.sv
// ----------------------------------------------------------------------------
// LCG encoder datapath
// Generator state, group phase, offset arithmetic and the output register.
// ----------------------------------------------------------------------------
module lcg_enc_dp
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lcg_enc_pkg::in_item_t   in_data,
    input  lcg_enc_pkg::dp_cmd_t    cmd,
    output lcg_enc_pkg::dp_status_t status,
    output logic                    out_valid,
    input  logic                    out_stall,
    output lcg_enc_pkg::out_item_t  out_data
);

    logic [31:0] lcg_reg, lcg_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  char_reg;
    logic        last_reg;
    logic [1:0]  site_reg;
    logic        site_valid_reg, site_valid_next;
    logic        out_valid_reg, out_valid_next;
    lcg_enc_pkg::out_item_t out_data_reg;

    logic [1:0]  quad;
    logic [2:0]  mult;
    logic        hit;
    logic [31:0] base;
    logic [31:0] drawn;
    logic [5:0]  offset;
    logic [5:0]  scaled;
    logic [5:0]  sum;

    assign quad   = cmd.idx[3:2];
    assign mult   = 3'({1'b0, cmd.idx[1:0]} + 3'd1);
    assign hit    = site_valid_reg && (quad == site_reg);
    assign base   = (hit && (cmd.idx[1:0] == 2'd0)) ? {24'd0, char_reg} : lcg_reg;
    assign drawn  = 32'(base * lcg_enc_pkg::LCG_MUL + lcg_enc_pkg::LCG_INC);
    assign offset = hit ? 6'd0 : {phase_reg, quad, 2'b01};
    assign scaled = 6'(offset * mult);
    assign sum    = 6'(drawn[21:16] + scaled);

    assign status.char_nonzero = (in_data.in_char != 8'd0);
    assign status.out_free     = !out_valid_reg || !out_stall;

    always_comb
    begin
        lcg_next        = lcg_reg;
        phase_next      = phase_reg;
        site_valid_next = site_valid_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (cmd.load)
        begin
            site_valid_next = 1'b0;
        end
        if (cmd.draw_site)
        begin
            lcg_next        = drawn;
            site_valid_next = 1'b1;
        end
        if (cmd.draw_out)
        begin
            lcg_next       = drawn;
            out_valid_next = 1'b1;
            if (cmd.idx == lcg_enc_pkg::LAST_IDX)
            begin
                phase_next = last_reg ? 2'd0 : 2'(phase_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_reg        <= lcg_enc_pkg::LCG_SEED;
            phase_reg      <= 2'd0;
            site_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            lcg_reg        <= lcg_next;
            phase_reg      <= phase_next;
            site_valid_reg <= site_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg <= in_data.in_char;
            last_reg <= in_data.last_group;
        end
        if (cmd.draw_site)
        begin
            site_reg <= lcg_next[17:16];
        end
        if (cmd.draw_out)
        begin
            out_data_reg.out_char    <= lcg_enc_pkg::alphabet(sum);
            out_data_reg.last_of_run <= (cmd.idx == lcg_enc_pkg::LAST_IDX);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/lcg_char_obfuscation_encoder_core.sv
// Throughput: one output character per cycle when not stalled, set by the single generator
// multiplier stepping once per draw; the next input waits until all sixteen draws are done.
// Reset: asynchronous active-low; generator state returns to 1 and the group phase to 0.
// ----------------------------------------------------------------------------
// LCG character obfuscation encoder
// Expands each input character into sixteen base64-alphabet characters.
// ----------------------------------------------------------------------------
module lcg_char_obfuscation_encoder_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  lcg_enc_pkg::in_item_t  in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output lcg_enc_pkg::out_item_t out_data
);

    lcg_enc_pkg::dp_cmd_t    cmd;
    lcg_enc_pkg::dp_status_t status;

    lcg_enc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lcg_enc_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
